[rtl/scatter_point_grid_plotter_assert.svh]
// ---------------------------------------------------------------------------
// scatter point grid plotter assertion macros
// shared property shorthands for the plotter modules
// ---------------------------------------------------------------------------
`ifndef SCATTER_POINT_GRID_PLOTTER_ASSERT_SVH
`define SCATTER_POINT_GRID_PLOTTER_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define SPG_ASSERT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define SPG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/spg_pkg.sv]
// ---------------------------------------------------------------------------
// spg_pkg
// types, sizes and character codes of the scatter point grid plotter
// ---------------------------------------------------------------------------
`default_nettype none

package spg_pkg;

    // grid bounds
    localparam int MAX_COLS  = 60;
    localparam int MAX_ROWS  = 64;
    localparam int ROW_W     = MAX_COLS;
    localparam int ROW_AW    = $clog2(MAX_ROWS);
    localparam int COL_AW    = 6;
    localparam int COLS_W    = 6;
    localparam int ROWS_W    = 7;
    localparam int LINE_W    = 7;

    // scaling divider
    localparam int QUO_W     = 6;
    localparam int STEP_W    = $clog2(QUO_W);
    localparam int PROD_W    = 32 + QUO_W;
    localparam int REM_W     = PROD_W + 2;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_Y = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COLS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MARK  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_BLANK = 3'd7;

    // operations
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_PLOT  = 2'd1;
    localparam logic [1:0] OP_EMIT  = 2'd2;

    // character codes
    localparam logic [7:0] CHAR_PLUS = 8'd43;
    localparam logic [7:0] CHAR_DASH = 8'd45;
    localparam logic [7:0] CHAR_BAR  = 8'd124;
    localparam logic [7:0] CHAR_NL   = 8'd10;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
    } t_in_word;

    typedef struct packed {
        logic [7:0] text_char;
        logic       line_end;
        logic       frame_end;
    } t_out_word;

    typedef struct packed {
        logic             start;
        logic [31:0]      num;
        logic [31:0]      den;
        logic [QUO_W-1:0] nm1;
    } t_scale_req;

    typedef struct packed {
        logic              clear;
        logic              rd_en;
        logic [ROW_AW-1:0] rd_addr;
        logic              wr_en;
        logic [ROW_AW-1:0] wr_addr;
        logic [ROW_W-1:0]  wr_data;
    } t_mem_req;

endpackage

`default_nettype wire

[rtl/spg_scale.sv]
// ---------------------------------------------------------------------------
// spg_scale
// shared scaling unit: round(num*nm1/den) by multiply then restoring divide
// ---------------------------------------------------------------------------
`default_nettype none
`include "scatter_point_grid_plotter_assert.svh"

module spg_scale
    import spg_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_scale_req       i_req,
    output logic                  o_done,
    output logic [QUO_W-1:0]      o_quo
);

    logic              r_busy;
    logic              r_load;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [31:0]       r_num;
    logic [31:0]       r_den;
    logic [QUO_W-1:0]  r_nm1;
    logic [REM_W-1:0]  r_rem;
    logic [QUO_W-1:0]  r_quo;

    logic [PROD_W-1:0] w_prod;
    logic [REM_W-1:0]  w_trial;
    logic              w_fit;

    assign w_prod  = PROD_W'(r_num) * PROD_W'(r_nm1);
    // divisor is 2*den, weighted by the quotient bit under test
    assign w_trial = {{(REM_W-33){1'b0}}, r_den, 1'b0} << r_step;
    assign w_fit   = (r_rem >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_load <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_load <= 1'b1;
            end else if (r_busy && r_load) begin
                r_load <= 1'b0;
            end else if (r_busy && r_step == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.num;
            r_den <= i_req.den;
            r_nm1 <= i_req.nm1;
            r_quo <= '0;
        end else if (r_busy && r_load) begin
            // dividend 2*num*nm1 + den gives rounding with halves up
            r_rem  <= {1'b0, w_prod, 1'b0} + REM_W'(r_den);
            r_step <= STEP_W'(QUO_W - 1);
        end else if (r_busy) begin
            if (w_fit) begin
                r_rem         <= r_rem - w_trial;
                r_quo[r_step] <= 1'b1;
            end
            r_step <= r_step - 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

    `SPG_ASSERT(a_quo_in_grid, i_clk, i_rst_n, r_done, r_quo <= r_nm1, "quotient beyond grid")
    `SPG_ASSERT(a_start_when_free, i_clk, i_rst_n, i_req.start, !r_busy, "start while busy")

endmodule

`default_nettype wire

[rtl/spg_mark_mem.sv]
// ---------------------------------------------------------------------------
// spg_mark_mem
// cell mark store: one row word per grid row, per-row valid bits for clear
// ---------------------------------------------------------------------------
`default_nettype none

module spg_mark_mem
    import spg_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_mem_req         i_req,
    output logic [ROW_W-1:0]      o_rd_data
);

    logic [ROW_W-1:0]    r_mem [MAX_ROWS];
    logic [MAX_ROWS-1:0] r_valid;
    logic [ROW_W-1:0]    r_rd_data;
    logic                r_rd_vld;

    // valid bits: a row never written since clear reads as empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.clear) begin
                r_valid <= '0;
            end else if (i_req.wr_en) begin
                r_valid[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_vld <= r_valid[i_req.rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

`default_nettype wire

[rtl/scatter_point_grid_plotter.sv]
// ---------------------------------------------------------------------------
// scatter_point_grid_plotter
// plots Q16.16 points through a viewport into a framed character grid
//
// input channel (valid/stall) takes one word: clear, plot or emit.
// config channel (valid/ready, always ready) writes viewport, grid size and
// the mark and blank characters; write only while the block is idle.
// output channel (valid/stall) gives one character word per beat.
// operations:
//   clear - no output words
//   plot  - for a point in view, two passes through the shared scaling unit
//           (load, 6 divide steps, done each) plus a row read and write
//   emit  - a row read unless the line is a border, then cols+3 words
//           at one per cycle, paced by the output register on receiver stalls
// the block stalls its input while any operation is in progress.
// reset: viewport -1..1 on both axes, 60 x 24 grid, all cells empty, next
// line is the top border; the mark store is cleared through valid bits.
// ---------------------------------------------------------------------------
`default_nettype none
`include "scatter_point_grid_plotter_assert.svh"

module scatter_point_grid_plotter
    import spg_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // item input
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_in_word             i_in_data,
    // configuration writes
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]          i_cfg_data,
    // character output
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out_word                 o_out_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CX   = 3'd1;   // scaling column
    localparam logic [2:0] S_CY   = 3'd2;   // scaling row
    localparam logic [2:0] S_PRD  = 3'd3;   // read target row
    localparam logic [2:0] S_PWR  = 3'd4;   // write row with new mark
    localparam logic [2:0] S_ERD  = 3'd5;   // row read for emit
    localparam logic [2:0] S_EMIT = 3'd6;   // stream characters

    // configuration registers
    logic signed [31:0] r_min_x, r_max_x, r_min_y, r_max_y;
    logic [COLS_W-1:0]  r_cols;
    logic [ROWS_W-1:0]  r_rows;
    logic [7:0]         r_mark_ch, r_blank_ch;

    // sequencer
    logic [2:0]         r_state, n_state;
    logic [LINE_W-1:0]  r_next;
    logic [31:0]        r_num_y, r_den_y;
    logic [COL_AW-1:0]  r_col_idx;
    logic [ROW_AW-1:0]  r_row_idx;

    // emit
    logic [5:0]         r_pos;
    logic               r_border, r_bottom;
    logic [ROW_W-1:0]   r_bits;
    logic               r_out_valid;
    t_out_word          r_out_data;

    logic               w_accept;
    logic [COLS_W-1:0]  w_cols;
    logic [ROWS_W-1:0]  w_rows;
    logic               w_in_view;
    logic               w_border;
    logic               w_emit_go;
    logic               w_left, w_right, w_last;
    t_out_word          w_word;
    t_scale_req         w_scale_req;
    logic               w_scale_done;
    logic [QUO_W-1:0]   w_quo;
    t_mem_req           w_mem_req;
    logic [ROW_W-1:0]   w_rd_data;

    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // ---- configuration ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_x    <= -32'sd65536;
            r_max_x    <= 32'sd65536;
            r_min_y    <= -32'sd65536;
            r_max_y    <= 32'sd65536;
            r_cols     <= COLS_W'(60);
            r_rows     <= ROWS_W'(24);
            r_mark_ch  <= 8'd42;
            r_blank_ch <= 8'd32;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_MIN_X: r_min_x    <= i_cfg_data;
                REG_MAX_X: r_max_x    <= i_cfg_data;
                REG_MIN_Y: r_min_y    <= i_cfg_data;
                REG_MAX_Y: r_max_y    <= i_cfg_data;
                REG_COLS:  r_cols     <= i_cfg_data[COLS_W-1:0];
                REG_ROWS:  r_rows     <= i_cfg_data[ROWS_W-1:0];
                REG_MARK:  r_mark_ch  <= i_cfg_data[7:0];
                REG_BLANK: r_blank_ch <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // grid size in use: zero counts as one, large values saturate
    always_comb begin
        if (r_cols == '0) begin
            w_cols = COLS_W'(1);
        end else if (r_cols > COLS_W'(MAX_COLS)) begin
            w_cols = COLS_W'(MAX_COLS);
        end else begin
            w_cols = r_cols;
        end
        if (r_rows == '0) begin
            w_rows = ROWS_W'(1);
        end else if (r_rows > ROWS_W'(MAX_ROWS)) begin
            w_rows = ROWS_W'(MAX_ROWS);
        end else begin
            w_rows = r_rows;
        end
    end

    // point must sit inside a viewport with positive extents, edges included
    assign w_in_view = (r_max_x > r_min_x) && (r_max_y > r_min_y)
                    && ($signed(i_in_data.point_x) >= r_min_x)
                    && ($signed(i_in_data.point_x) <= r_max_x)
                    && ($signed(i_in_data.point_y) >= r_min_y)
                    && ($signed(i_in_data.point_y) <= r_max_y);

    // line zero and anything past the last row are border lines
    assign w_border = (r_next == '0) || (r_next > LINE_W'(w_rows));

    // ---- sequencer ----
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in_data.operation == OP_PLOT && w_in_view) begin
                        n_state = S_CX;
                    end else if (i_in_data.operation == OP_EMIT) begin
                        n_state = w_border ? S_EMIT : S_ERD;
                    end
                end
            end
            S_CX:   if (w_scale_done) n_state = S_CY;
            S_CY:   if (w_scale_done) n_state = S_PRD;
            S_PRD:  n_state = S_PWR;
            S_PWR:  n_state = S_IDLE;
            S_ERD:  n_state = S_EMIT;
            S_EMIT: if (w_emit_go && w_last) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_next  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE && w_accept && i_in_data.operation == OP_CLEAR) begin
                r_next <= '0;
            end else if (w_emit_go && w_last) begin
                if (r_border) begin
                    r_next <= r_bottom ? LINE_W'(0) : LINE_W'(1);
                end else begin
                    r_next <= r_next + 1'b1;
                end
            end
        end
    end

    // y operands wait while the column is scaled
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && w_accept) begin
            r_num_y  <= r_max_y - i_in_data.point_y;
            r_den_y  <= r_max_y - r_min_y;
            r_pos    <= '0;
            r_border <= w_border;
            r_bottom <= (r_next != '0);
        end
        if (r_state == S_CX && w_scale_done) begin
            r_col_idx <= w_quo;
        end
        if (r_state == S_CY && w_scale_done) begin
            r_row_idx <= ROW_AW'(w_quo);
        end
        if (r_state == S_ERD) begin
            r_bits <= w_rd_data;
        end
        if (w_emit_go) begin
            r_pos <= r_pos + 1'b1;
            // cell characters consume the row word from bit zero up
            if (!w_left && !w_right && !w_last) begin
                r_bits <= r_bits >> 1;
            end
        end
    end

    // ---- shared scaling unit ----
    always_comb begin
        w_scale_req = '0;
        if (r_state == S_IDLE) begin
            w_scale_req.start = w_accept && i_in_data.operation == OP_PLOT && w_in_view;
            w_scale_req.num   = i_in_data.point_x - r_min_x;
            w_scale_req.den   = r_max_x - r_min_x;
            w_scale_req.nm1   = QUO_W'(w_cols - 1'b1);
        end else begin
            w_scale_req.start = (r_state == S_CX) && w_scale_done;
            w_scale_req.num   = r_num_y;
            w_scale_req.den   = r_den_y;
            w_scale_req.nm1   = QUO_W'(w_rows - 1'b1);
        end
    end

    spg_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_scale_req),
        .o_done  (w_scale_done),
        .o_quo   (w_quo)
    );

    // ---- mark store ----
    always_comb begin
        w_mem_req         = '0;
        w_mem_req.clear   = (r_state == S_IDLE) && w_accept
                         && (i_in_data.operation == OP_CLEAR);
        w_mem_req.wr_en   = (r_state == S_PWR);
        w_mem_req.wr_addr = r_row_idx;
        w_mem_req.wr_data = w_rd_data | (ROW_W'(1) << r_col_idx);
        if (r_state == S_IDLE) begin
            w_mem_req.rd_en   = w_accept && (i_in_data.operation == OP_EMIT) && !w_border;
            w_mem_req.rd_addr = ROW_AW'(r_next - 1'b1);
        end else begin
            w_mem_req.rd_en   = (r_state == S_PRD);
            w_mem_req.rd_addr = r_row_idx;
        end
    end

    spg_mark_mem u_marks (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_mem_req),
        .o_rd_data (w_rd_data)
    );

    // ---- line emitter ----
    assign w_emit_go = (r_state == S_EMIT) && (!r_out_valid || !i_out_stall);
    assign w_left    = (r_pos == '0);
    assign w_right   = (r_pos == w_cols + 6'd1);
    assign w_last    = (r_pos == w_cols + 6'd2);

    always_comb begin
        w_word = '0;
        if (w_last) begin
            w_word.text_char = CHAR_NL;
            w_word.line_end  = 1'b1;
            w_word.frame_end = r_border && r_bottom;
        end else if (w_left || w_right) begin
            w_word.text_char = r_border ? CHAR_PLUS : CHAR_BAR;
        end else if (r_border) begin
            w_word.text_char = CHAR_DASH;
        end else begin
            w_word.text_char = r_bits[0] ? r_mark_ch : r_blank_ch;
        end
    end

    // output register holds each word while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit_go) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit_go) begin
            r_out_data <= w_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `SPG_ASSERT(a_frame_on_newline, i_clk, i_rst_n, o_out_valid && o_out_data.frame_end, o_out_data.line_end, "frame end off newline")
    `SPG_ASSERT_NEXT(a_emit_starts, i_clk, i_rst_n, w_accept && i_in_data.operation == OP_EMIT, r_state == S_EMIT || r_state == S_ERD, "emit did not start")

endmodule

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scatter point grid plotter testbench
// drives clear, plot and emit words through random viewport and grid
// settings, predicts every framed text character and checks each output word
// against the oldest prediction, with random idling on both channels
// ---------------------------------------------------------------------------

import spg_pkg::*;

// tracks the plotter state and the characters still to come out
class grid_scoreboard;
    logic signed [31:0]  min_x, max_x, min_y, max_y;
    logic [COLS_W-1:0]   cols_reg;
    logic [ROWS_W-1:0]   rows_reg;
    logic [7:0]          mark_code, blank_code;
    logic [MAX_COLS-1:0] marks [MAX_ROWS];
    int unsigned         line_no;
    t_out_word           pending_chars [$];
    int                  errors;

    function new();
        min_x      = 32'hFFFF_0000;
        max_x      = 32'h0001_0000;
        min_y      = 32'hFFFF_0000;
        max_y      = 32'h0001_0000;
        cols_reg   = 6'd60;
        rows_reg   = 7'd24;
        mark_code  = 8'd42;
        blank_code = 8'd32;
        foreach (marks[i]) marks[i] = '0;
        line_no    = 0;
        errors     = 0;
    endfunction

    function int used_cols();
        if (cols_reg == 0) return 1;
        if (cols_reg > MAX_COLS) return MAX_COLS;
        return int'(cols_reg);
    endfunction

    function int used_rows();
        if (rows_reg == 0) return 1;
        if (rows_reg > MAX_ROWS) return MAX_ROWS;
        return int'(rows_reg);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
        case (idx)
            REG_MIN_X: min_x = d;
            REG_MAX_X: max_x = d;
            REG_MIN_Y: min_y = d;
            REG_MAX_Y: max_y = d;
            REG_COLS:  cols_reg = d[COLS_W-1:0];
            REG_ROWS:  rows_reg = d[ROWS_W-1:0];
            REG_MARK:  mark_code = d[7:0];
            REG_BLANK: blank_code = d[7:0];
            default: ;
        endcase
    endfunction

    function void push_char(logic [7:0] c, logic le, logic fe);
        t_out_word w;
        w.text_char = c;
        w.line_end  = le;
        w.frame_end = fe;
        pending_chars.push_back(w);
    endfunction

    // an accepted input word: update state, queue the characters it causes
    function void note_word(t_in_word w);
        longint              x, y, ex, ey, n_cols, n_rows, c, r;
        logic                bottom;
        logic [MAX_COLS-1:0] row_bits;
        int                  i;
        n_cols = used_cols();
        n_rows = used_rows();
        x  = longint'($signed(w.point_x));
        y  = longint'($signed(w.point_y));
        ex = longint'(max_x) - longint'(min_x);
        ey = longint'(max_y) - longint'(min_y);
        case (w.operation)
            OP_CLEAR: begin
                foreach (marks[k]) marks[k] = '0;
                line_no = 0;
            end
            OP_PLOT: begin
                // empty or inverted viewport, or point off the edges: no mark
                if (ex > 0 && ey > 0 && x >= min_x && x <= max_x
                        && y >= min_y && y <= max_y) begin
                    // round half up: floor((2*d*(n-1) + e) / (2*e))
                    c = (2 * (x - min_x) * (n_cols - 1) + ex) / (2 * ex);
                    r = (2 * (max_y - y) * (n_rows - 1) + ey) / (2 * ey);
                    if (c >= n_cols) c = n_cols - 1;
                    if (r >= n_rows) r = n_rows - 1;
                    marks[r][c] = 1'b1;
                end
            end
            OP_EMIT: begin
                if (line_no == 0 || line_no > n_rows) begin
                    // border line; past the grid it is the bottom one
                    bottom = (line_no != 0);
                    push_char(CHAR_PLUS, 1'b0, 1'b0);
                    for (i = 0; i < n_cols; i++) push_char(CHAR_DASH, 1'b0, 1'b0);
                    push_char(CHAR_PLUS, 1'b0, 1'b0);
                    push_char(CHAR_NL, 1'b1, bottom);
                    line_no = bottom ? 0 : 1;
                end else begin
                    row_bits = marks[line_no - 1];
                    push_char(CHAR_BAR, 1'b0, 1'b0);
                    for (i = 0; i < n_cols; i++)
                        push_char(row_bits[i] ? mark_code : blank_code, 1'b0, 1'b0);
                    push_char(CHAR_BAR, 1'b0, 1'b0);
                    push_char(CHAR_NL, 1'b1, 1'b0);
                    line_no++;
                end
            end
            default: ;
        endcase
    endfunction

    function void check_char(t_out_word got);
        t_out_word want;
        if (pending_chars.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected word: char %0d le %0b fe %0b",
                         got.text_char, got.line_end, got.frame_end);
            return;
        end
        want = pending_chars.pop_front();
        if (got.text_char !== want.text_char || got.line_end !== want.line_end
                || got.frame_end !== want.frame_end) begin
            errors++;
            if (errors <= 10)
                $display("mismatch: expected char %0d le %0b fe %0b, got char %0d le %0b fe %0b",
                         want.text_char, want.line_end, want.frame_end,
                         got.text_char, got.line_end, got.frame_end);
        end
    endfunction
endclass

module testbench;

    localparam int         IDLE_LIMIT  = 3000;  // cycles without any handshake
    localparam int         HOLD_OFF    = 48;    // settle wait before each phase
    localparam int         PHASE_ITEMS = 36;
    localparam int         PHASES      = 9;
    localparam logic [1:0] OP_UNUSED   = 2'd3;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_in_word             i_in_data;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [31:0]          i_cfg_data;
    logic                 o_out_valid;
    logic                 i_out_stall;
    t_out_word            o_out_data;

    grid_scoreboard sb;
    int             idle_cycles = 0;
    int             sent_count  = 0;
    int             in_calm     = 0;

    scatter_point_grid_plotter DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // handshake monitor: predictions on accepted inputs and config
    // writes, checks on accepted output words, plus the idle watchdog
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) sb.write_reg(i_cfg_index, i_cfg_data);
            if (i_in_valid && !o_in_stall) sb.note_word(i_in_data);
            if (o_out_valid && !i_out_stall) sb.check_char(o_out_data);
            if ((i_cfg_valid && o_cfg_ready) || (i_in_valid && !o_in_stall)
                    || (o_out_valid && !i_out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver stall pattern: free runs, short stalls, rare long stalls
    // ------------------------------------------------------------------
    initial begin : stall_gen
        int left;
        int r;
        left = 0;
        forever begin
            @(posedge i_clk);
            if (left > 0) begin
                left--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 40) begin
                    i_out_stall <= 1'b0;
                    left = $urandom_range(1, 30) - 1;
                end else if (r < 50) begin
                    // long stretch with no stalls at all
                    i_out_stall <= 1'b0;
                    left = $urandom_range(50, 200) - 1;
                end else if (r < 90) begin
                    i_out_stall <= 1'b1;
                    left = $urandom_range(1, 3) - 1;
                end else if (r < 98) begin
                    i_out_stall <= 1'b1;
                    left = $urandom_range(4, 12) - 1;
                end else begin
                    i_out_stall <= 1'b1;
                    left = $urandom_range(30, 60) - 1;
                end
            end
        end
    end

    // sender gap before the next word; mostly short, a few long, some calm runs
    function automatic int in_gap();
        int r;
        if (in_calm > 0) begin
            in_calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            in_calm = $urandom_range(10, 40);
            return 0;
        end
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // one word on the input channel; valid stays up into the next word
    // when there is no gap
    task automatic send_word(logic [1:0] op, logic [31:0] x, logic [31:0] y);
        t_in_word w;
        int       gap;
        w.operation = op;
        w.point_x   = x;
        w.point_y   = y;
        gap = in_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do @(posedge i_clk); while (o_in_stall);
        if (op != OP_UNUSED) sent_count++;
    endtask

    // drop valid, wait for every expected character, then hold off a while
    task automatic settle(int hold);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_chars.size() != 0) @(posedge i_clk);
        repeat (hold) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_all(logic [31:0] mnx, logic [31:0] mxx, logic [31:0] mny,
                             logic [31:0] mxy, logic [5:0] cols, logic [6:0] rows,
                             logic [7:0] mk, logic [7:0] bl);
        cfg_write(REG_MIN_X, mnx);
        cfg_write(REG_MAX_X, mxx);
        cfg_write(REG_MIN_Y, mny);
        cfg_write(REG_MAX_Y, mxy);
        cfg_write(REG_COLS, {26'd0, cols});
        cfg_write(REG_ROWS, {25'd0, rows});
        cfg_write(REG_MARK, {24'd0, mk});
        cfg_write(REG_BLANK, {24'd0, bl});
    endtask

    // random edges: wide, narrow, or now and then empty / inverted
    task automatic pick_span(output logic [31:0] lo, output logic [31:0] hi);
        lo = $urandom;
        case ($urandom_range(0, 7))
            0, 1: begin
                hi = $urandom;
                if ($signed(hi) < $signed(lo)) begin
                    hi = lo;
                    lo = $urandom_range(0, 1) ? 32'h8000_0000 : lo - $urandom_range(1, 1000);
                end
            end
            7: hi = lo - $urandom_range(0, 1000);
            default: begin
                lo = {{12{lo[31]}}, lo[19:0]};
                hi = lo + $urandom_range(1, 32'h0004_0000);
            end
        endcase
    endtask

    task automatic random_setup();
        logic [31:0] lx, hx, ly, hy;
        logic [5:0]  cols;
        logic [6:0]  rows;
        pick_span(lx, hx);
        pick_span(ly, hy);
        cols = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                           : 6'($urandom_range(1, 16));
        rows = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127))
                                           : 7'($urandom_range(1, 10));
        write_all(lx, hx, ly, hy, cols, rows, 8'($urandom), 8'($urandom));
    endtask

    // coordinate inside [lo, hi], edges included; anything if the span is inverted
    function automatic logic [31:0] coord_in(logic signed [31:0] lo, logic signed [31:0] hi);
        longint span;
        span = longint'(hi) - longint'(lo);
        if (span < 0) return $urandom;
        case ($urandom_range(0, 9))
            0: return lo;
            1: return hi;
            default: return 32'(longint'(lo) + ((span * $urandom_range(0, 65535)) >>> 16));
        endcase
    endfunction

    task automatic plot_inside();
        send_word(OP_PLOT, coord_in(sb.min_x, sb.max_x), coord_in(sb.min_y, sb.max_y));
    endtask

    // a mix of everything, including noise points and the unused code
    task automatic random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            send_word(OP_CLEAR, $urandom, $urandom);
        else if (r < 50)
            plot_inside();
        else if (r < 60)
            send_word(OP_PLOT, $urandom, $urandom);
        else if (r < 63)
            send_word(OP_UNUSED, $urandom, $urandom);
        else
            send_word(OP_EMIT, $urandom, $urandom);
    endtask

    // well-formed picture: clear (mostly), some points, then a whole frame
    task automatic draw_frame();
        int n;
        if ($urandom_range(0, 3) != 0) send_word(OP_CLEAR, $urandom, $urandom);
        repeat ($urandom_range(1, 10)) plot_inside();
        n = sb.used_rows() + 2;
        repeat (n) send_word(OP_EMIT, $urandom, $urandom);
    endtask

    task automatic run_random(int budget);
        int target;
        int iter;
        target = sent_count + budget;
        iter = 0;
        while (sent_count < target) begin
            // sender holds back until the output has drained
            if (iter == 2 || $urandom_range(0, 29) == 0) settle(0);
            if ($urandom_range(0, 2) == 0)
                draw_frame();
            else
                repeat ($urandom_range(1, 6)) random_item();
            iter++;
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        sb = new();
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= REG_MIN_X;
        i_cfg_data  <= '0;
        i_out_stall <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at reset settings: viewport -1..1, 60 x 24 grid
        send_word(OP_CLEAR, 32'h0, 32'h0);
        send_word(OP_EMIT, 32'h0, 32'h0);                  // full width top border
        send_word(OP_PLOT, 32'h0000_0000, 32'h0000_0000);  // halfway on both axes
        send_word(OP_PLOT, 32'hFFFF_0000, 32'hFFFF_0000);  // lower left corner
        send_word(OP_PLOT, 32'h0001_0000, 32'h0001_0000);  // upper right corner
        send_word(OP_PLOT, 32'h0001_0001, 32'h0000_0000);  // just right of the view
        send_word(OP_PLOT, 32'h0000_0000, 32'hFFFE_FFFF);  // just below the view
        send_word(OP_PLOT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_word(OP_PLOT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_word(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(OP_PLOT, 32'h0000_8000, 32'hFFFF_8000);
        // leave the line counter at 13 so the next phase starts past its grid
        repeat (12) send_word(OP_EMIT, 32'h0, 32'h0);

        for (int ph = 1; ph <= PHASES; ph++) begin
            settle(HOLD_OFF);
            case (ph)
                1: write_all(32'hFFFD_0000, 32'h0003_0000, 32'hFFFE_0000, 32'h0002_0000,
                             6'd10, 7'd5, 8'h23, 8'h2E);
                2: write_all(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                             6'd60, 7'd64, 8'hFF, 8'h00);
                // zero counts behave as one
                3: write_all(32'h0, 32'h1, 32'h0, 32'h1, 6'd0, 7'd0, 8'h00, 8'hFF);
                // counts above the bounds saturate
                4: write_all(32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000,
                             6'd63, 7'd127, 8'h6F, 8'h20);
                // inverted x extent and empty y extent: plots do nothing
                5: write_all(32'h0001_0000, 32'hFFFF_0000, 32'h0000_0000, 32'h0000_0000,
                             6'd8, 7'd4, 8'($urandom), 8'($urandom));
                default: random_setup();
            endcase
            // no clear first: old marks show in the new characters and sizes
            send_word(OP_EMIT, $urandom, $urandom);
            run_random(PHASE_ITEMS);
        end

        settle(HOLD_OFF);
        sb.errors += sb.pending_chars.size();
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
